[sv/fci_pkg.sv]
package fci_pkg;

  // Store geometry.
  localparam int unsigned BANK_BYTES   = 65536;
  localparam int unsigned BANK_COUNT   = 2;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned STORE_BYTES  = BANK_BYTES * BANK_COUNT;

  // Derived widths: byte offset in a bank, store address, fill counter.
  localparam int unsigned OFFS_W = $clog2(BANK_BYTES);
  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned FILL_W = $clog2(STORE_BYTES + 1);

  // Fixed bus addresses of the command sequence.
  localparam logic [31:0] ADDR_UNLOCK1 = 32'h0E00_5555;
  localparam logic [31:0] ADDR_UNLOCK2 = 32'h0E00_2AAA;
  localparam logic [31:0] ADDR_BASE    = 32'h0E00_0000;
  localparam logic [31:0] SECTOR_MASK  = 32'h0000_F000;

  // Unlock bytes and command bytes.
  localparam logic [7:0] UNLOCK_BYTE1     = 8'hAA;
  localparam logic [7:0] UNLOCK_BYTE2     = 8'h55;
  localparam logic [7:0] CMD_ID_ENTER     = 8'h90;
  localparam logic [7:0] CMD_ID_LEAVE     = 8'hF0;
  localparam logic [7:0] CMD_ERASE_ARM    = 8'h80;
  localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [7:0] CMD_BANK_SELECT  = 8'hB0;
  localparam logic [7:0] ERASED_BYTE      = 8'hFF;

  // Access kinds on the input channel.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LARGE_PART  = 2'd0;
  localparam logic [1:0] CFG_MAKER_ID    = 2'd1;
  localparam logic [1:0] CFG_DEVICE_CODE = 2'd2;

  // Reduce a 16-bit bus offset into a bank. The quotient is below 16 since
  // a bank holds at least 4 KB, so four conditional subtracts suffice.
  function automatic logic [OFFS_W-1:0] bank_offset(input logic [15:0] low);
    logic [20:0] rem;
    logic [20:0] step;
    rem = {5'd0, low};
    for (int k = 3; k >= 0; k--) begin
      step = 21'(BANK_BYTES) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return OFFS_W'(rem);
  endfunction

endpackage

[sv/flash_command_interface.sv]
// A write is executed in S_EXEC; the next item is taken once the block is back in S_IDLE.
// A read passes S_EXEC (store read) and S_RESP, which waits for a free output register.
// Chip erase fills the whole store, STORE_BYTES (131072) bytes, one byte a cycle.
// Sector erase fills one sector, up to 4096 bytes, the same way.
// After rst_n the same fill clears the store; in_ready stays low until it is done.
// Configuration writes are taken in every cycle, also during a fill.
module flash_command_interface (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import fci_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP,
    S_FILL
  } state_t;

  typedef enum logic [1:0] {
    PH_ACCEPT,
    PH_AFTER_AA,
    PH_COMMAND,
    PH_OPERAND
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic id_mode_r, id_mode_nxt;
  logic erase_armed_r, erase_armed_nxt;
  logic prog_pend_r, prog_pend_nxt;
  logic bank_pend_r, bank_pend_nxt;
  logic bank_sel_r, bank_sel_nxt;
  logic [FILL_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [FILL_W-1:0] fill_end_r, fill_end_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;

  logic large_part_r;
  logic [7:0] maker_id_r;
  logic [7:0] device_code_r;

  // Accepted item.
  logic        cmd_r;
  logic [31:0] addr_r;
  logic [7:0]  wbyte_r;

  // Store ports.
  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_r;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // Address mapping of the held item.
  logic              eff_bank;
  logic [FILL_W-1:0] bank_base;
  logic [OFFS_W-1:0] item_off;
  logic [FILL_W-1:0] map_wide;
  logic [ADDR_W-1:0] map_addr;
  logic [OFFS_W-1:0] sec_off;
  logic [FILL_W-1:0] sec_lim;
  logic [FILL_W-1:0] sec_start;
  logic [FILL_W-1:0] sec_end;
  logic [FILL_W-1:0] fill_inc;

  logic in_xfer;
  logic out_xfer;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_byte = out_byte_r;
  assign cfg_ready     = 1'b1;
  assign in_xfer       = in_valid && in_ready;
  assign out_xfer      = out_valid_r && out_ready;

  // Bank selection only counts on a two-bank part with bank select enabled.
  assign eff_bank  = (BANK_COUNT > 1) && large_part_r && bank_sel_r;
  assign bank_base = eff_bank ? FILL_W'(BANK_BYTES) : '0;
  assign item_off  = bank_offset(addr_r[15:0]);
  assign map_wide  = bank_base + FILL_W'(item_off);
  assign map_addr  = map_wide[ADDR_W-1:0];

  // Sector bounds: a sector that runs past the bank end is cut at the bank end.
  assign sec_off   = bank_offset(addr_r[15:0] & SECTOR_MASK[15:0]);
  assign sec_start = bank_base + FILL_W'(sec_off);
  assign sec_lim   = FILL_W'(sec_off) + FILL_W'(SECTOR_BYTES);
  assign sec_end   = (sec_lim > FILL_W'(BANK_BYTES)) ? (bank_base + FILL_W'(BANK_BYTES))
                                                     : (bank_base + sec_lim);

  // The incrementer that walks the fill address.
  assign fill_inc = fill_cnt_r + FILL_W'(1);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    id_mode_nxt     = id_mode_r;
    erase_armed_nxt = erase_armed_r;
    prog_pend_nxt   = prog_pend_r;
    bank_pend_nxt   = bank_pend_r;
    bank_sel_nxt    = bank_sel_r;
    fill_cnt_nxt    = fill_cnt_r;
    fill_end_nxt    = fill_end_r;
    out_valid_nxt   = out_xfer ? 1'b0 : out_valid_r;
    out_byte_nxt    = out_byte_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = map_addr;
    wr_data         = wbyte_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_r == ACC_READ) begin
          rd_en     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_IDLE;
          unique case (phase_r)
            PH_ACCEPT: begin
              if (addr_r == ADDR_UNLOCK1 && wbyte_r == UNLOCK_BYTE1) begin
                phase_nxt = PH_AFTER_AA;
              end
            end
            PH_AFTER_AA: begin
              if (addr_r == ADDR_UNLOCK2 && wbyte_r == UNLOCK_BYTE2) begin
                phase_nxt = PH_COMMAND;
              end
            end
            PH_COMMAND: begin
              phase_nxt = PH_ACCEPT;
              if (addr_r == ADDR_UNLOCK1) begin
                if (wbyte_r == CMD_ID_ENTER) begin
                  id_mode_nxt = 1'b1;
                end else if (wbyte_r == CMD_ID_LEAVE) begin
                  id_mode_nxt = 1'b0;
                end else if (wbyte_r == CMD_ERASE_ARM) begin
                  erase_armed_nxt = 1'b1;
                end else if (wbyte_r == CMD_PROGRAM) begin
                  phase_nxt     = PH_OPERAND;
                  prog_pend_nxt = 1'b1;
                end else if (wbyte_r == CMD_BANK_SELECT && large_part_r) begin
                  phase_nxt     = PH_OPERAND;
                  bank_pend_nxt = 1'b1;
                end else if (erase_armed_r && wbyte_r == CMD_CHIP_ERASE) begin
                  erase_armed_nxt = 1'b0;
                  fill_cnt_nxt    = '0;
                  fill_end_nxt    = FILL_W'(STORE_BYTES);
                  state_nxt       = S_FILL;
                end
              end else if ((addr_r & ~SECTOR_MASK) == ADDR_BASE && erase_armed_r &&
                           wbyte_r == CMD_SECTOR_ERASE) begin
                erase_armed_nxt = 1'b0;
                fill_cnt_nxt    = sec_start;
                fill_end_nxt    = sec_end;
                state_nxt       = S_FILL;
              end
            end
            PH_OPERAND: begin
              phase_nxt = PH_ACCEPT;
              if (bank_pend_r && addr_r == ADDR_BASE) begin
                bank_sel_nxt  = wbyte_r[0];
                bank_pend_nxt = 1'b0;
              end else begin
                wr_en         = 1'b1;
                prog_pend_nxt = 1'b0;
              end
            end
          endcase
        end
      end

      // Hand the read result, or an ID byte in ID mode, to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (id_mode_r && addr_r[15:1] == 15'd0) begin
            out_byte_nxt = addr_r[0] ? device_code_r : maker_id_r;
          end else begin
            out_byte_nxt = rdata_r;
          end
        end
      end

      // Write the erased value one byte a cycle up to the end address.
      S_FILL: begin
        wr_en        = 1'b1;
        wr_addr      = fill_cnt_r[ADDR_W-1:0];
        wr_data      = ERASED_BYTE;
        fill_cnt_nxt = fill_inc;
        if (fill_inc == fill_end_r) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // State and registered outputs. Reset starts the clearing pass over the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_FILL;
      phase_r       <= PH_ACCEPT;
      id_mode_r     <= 1'b0;
      erase_armed_r <= 1'b0;
      prog_pend_r   <= 1'b0;
      bank_pend_r   <= 1'b0;
      bank_sel_r    <= 1'b0;
      fill_cnt_r    <= '0;
      fill_end_r    <= FILL_W'(STORE_BYTES);
      out_valid_r   <= 1'b0;
      out_byte_r    <= 8'd0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      id_mode_r     <= id_mode_nxt;
      erase_armed_r <= erase_armed_nxt;
      prog_pend_r   <= prog_pend_nxt;
      bank_pend_r   <= bank_pend_nxt;
      bank_sel_r    <= bank_sel_nxt;
      fill_cnt_r    <= fill_cnt_nxt;
      fill_end_r    <= fill_end_nxt;
      out_valid_r   <= out_valid_nxt;
      out_byte_r    <= out_byte_nxt;
    end
  end

  // Hold the accepted item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_command;
      addr_r  <= in_bus_address;
      wbyte_r <= in_write_byte;
    end
  end

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_part_r  <= 1'b0;
      maker_id_r    <= 8'd0;
      device_code_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LARGE_PART:  large_part_r  <= cfg_data[0];
        CFG_MAKER_ID:    maker_id_r    <= cfg_data;
        CFG_DEVICE_CODE: device_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[map_addr];
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> !in_ready)
    else $error("input taken during a store fill");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (fill_cnt_r < fill_end_r))
    else $error("fill address passed its end");

  a_operand_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OPERAND) |-> (prog_pend_r || bank_pend_r))
    else $error("operand phase without a pending program or bank select");

  a_resp_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |=> out_valid_r)
    else $error("read response lost");
`endif

endmodule

[verif/flash_command_interface_checker.sv]
`timescale 1ns / 1ps

// Watches the access, read data and register channels of the flash command
// interface, keeps its own copy of the flash state and compares read data.
module flash_command_interface_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_command,
  input  logic [31:0]       in_bus_address,
  input  logic [7:0]        in_write_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_read_byte,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output int unsigned       mismatches,
  output int unsigned       reads_in_flight
);
  import fci_pkg::*;

  // Position in the unlock and command sequence.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_GOT_AA,
    SEQ_GOT_55,
    SEQ_OPERAND
  } seq_t;

  // Mirror of the flash contents and command state.
  logic [7:0] cells [STORE_BYTES];
  logic       bank_sel;
  seq_t       seq_phase;
  logic       id_mode;
  logic       erase_armed;
  logic       program_pending;
  logic       bank_pending;

  // Mirror of the register file.
  logic       large_part;
  logic [7:0] maker_id;
  logic [7:0] device_code;

  // Read data still owed by the block, oldest first.
  logic [7:0] read_data_q [$];

  // Start of the bank that reads and programs map into.
  function automatic int unsigned bank_base();
    return (large_part && BANK_COUNT > 1 && bank_sel) ? BANK_BYTES : 0;
  endfunction

  // Sets a run of store bytes back to the erased value.
  function automatic void fill_erased(input int unsigned first, input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      cells[first + k] = ERASED_BYTE;
    end
  endfunction

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin : track
    logic [7:0]  want;
    int unsigned offs;
    int unsigned len;
    if (!rst_n) begin
      fill_erased(0, STORE_BYTES);
      bank_sel        = 1'b0;
      seq_phase       = SEQ_IDLE;
      id_mode         = 1'b0;
      erase_armed     = 1'b0;
      program_pending = 1'b0;
      bank_pending    = 1'b0;
      large_part      = 1'b0;
      maker_id        = 8'h00;
      device_code     = 8'h00;
      mismatches      = 0;
      read_data_q.delete();
    end else begin
      // Read data transfer: compare against the oldest predicted byte.
      if (out_valid && out_ready) begin
        if (read_data_q.size() == 0) begin
          report($sformatf("read data %02h with no read outstanding", out_read_byte));
        end else begin
          want = read_data_q.pop_front();
          if (out_read_byte !== want) begin
            report($sformatf("read_byte: expected %02h got %02h", want, out_read_byte));
          end
        end
      end

      // Register write transfer; unused indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LARGE_PART:  large_part  = cfg_data[0];
          CFG_MAKER_ID:    maker_id    = cfg_data;
          CFG_DEVICE_CODE: device_code = cfg_data;
          default: ;
        endcase
      end

      // Access transfer: a read predicts its data, a write steps the sequencer.
      if (in_valid && in_ready) begin
        if (in_command == ACC_READ) begin
          if (id_mode && in_bus_address[15:0] < 2) begin
            want = in_bus_address[0] ? device_code : maker_id;
          end else begin
            want = cells[bank_base() + in_bus_address[15:0] % BANK_BYTES];
          end
          read_data_q.push_back(want);
        end else begin
          case (seq_phase)
            SEQ_IDLE: begin
              if (in_bus_address == ADDR_UNLOCK1 && in_write_byte == UNLOCK_BYTE1) begin
                seq_phase = SEQ_GOT_AA;
              end
            end
            SEQ_GOT_AA: begin
              if (in_bus_address == ADDR_UNLOCK2 && in_write_byte == UNLOCK_BYTE2) begin
                seq_phase = SEQ_GOT_55;
              end
            end
            SEQ_GOT_55: begin
              seq_phase = SEQ_IDLE;
              if (in_bus_address == ADDR_UNLOCK1) begin
                if (in_write_byte == CMD_ID_ENTER) begin
                  id_mode = 1'b1;
                end else if (in_write_byte == CMD_ID_LEAVE) begin
                  id_mode = 1'b0;
                end else if (in_write_byte == CMD_ERASE_ARM) begin
                  erase_armed = 1'b1;
                end else if (in_write_byte == CMD_PROGRAM) begin
                  seq_phase       = SEQ_OPERAND;
                  program_pending = 1'b1;
                end else if (in_write_byte == CMD_BANK_SELECT && large_part) begin
                  seq_phase    = SEQ_OPERAND;
                  bank_pending = 1'b1;
                end else if (erase_armed && in_write_byte == CMD_CHIP_ERASE) begin
                  erase_armed = 1'b0;
                  fill_erased(0, STORE_BYTES);
                end
              end else if ((in_bus_address & ~SECTOR_MASK) == ADDR_BASE && erase_armed &&
                           in_write_byte == CMD_SECTOR_ERASE) begin
                // A sector erase never runs past the end of its bank.
                erase_armed = 1'b0;
                offs = (in_bus_address & SECTOR_MASK) % BANK_BYTES;
                len  = (offs + SECTOR_BYTES > BANK_BYTES) ? BANK_BYTES - offs : SECTOR_BYTES;
                fill_erased(bank_base() + offs, len);
              end
            end
            default: begin
              // Operand byte: a bank number after a bank select at the base address, else program data.
              seq_phase = SEQ_IDLE;
              if (bank_pending && in_bus_address == ADDR_BASE) begin
                bank_sel     = in_write_byte[0];
                bank_pending = 1'b0;
              end else begin
                cells[bank_base() + in_bus_address[15:0] % BANK_BYTES] = in_write_byte;
                program_pending = 1'b0;
              end
            end
          endcase
        end
      end
    end
    reads_in_flight <= read_data_q.size();
  end

endmodule

[verif/flash_command_interface_tb.sv]
`timescale 1ns / 1ps

module flash_command_interface_tb;
  import fci_pkg::*;

  // Cycles without any transfer before the run is declared hung. The slowest
  // correct stretch is a full-store fill.
  localparam int unsigned WATCHDOG_LIMIT = 500_000;
  localparam logic [1:0]  CFG_UNUSED     = 2'd3;
  localparam int unsigned PHASE_ITEMS    = 160;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [31:0] in_bus_address;
  logic [7:0]  in_write_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int unsigned mismatches;
  int unsigned reads_in_flight;

  // Sender burst state, access count and addresses worth reading back.
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned chip_erases_left;
  logic [31:0] programmed_addrs [$];

  flash_command_interface dut (.*);

  flash_command_interface_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hang detection: count cycles in which no channel completes a transfer.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("flash_command_interface: mismatch");
    $finish;
  end

  // Read data receiver: switches between always ready, random stalls and a
  // fixed duty pattern.
  initial begin : receiver
    int unsigned mode;
    int unsigned run_left;
    int unsigned tick;
    out_ready = 1'b0;
    run_left  = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        mode     = $urandom_range(0, 2);
        run_left = $urandom_range(20, 200);
      end
      run_left--;
      tick++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ((tick % 5) < 2);
      endcase
    end
  end

  // One access transfer. The sender runs in bursts with random gaps between.
  task automatic bus_access(input logic cmd, input logic [31:0] addr, input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_bus_address <= addr;
    in_write_byte  <= data;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic bus_read(input logic [31:0] addr);
    bus_access(ACC_READ, addr, 8'($urandom()));
  endtask

  task automatic bus_write(input logic [31:0] addr, input logic [7:0] data);
    bus_access(ACC_WRITE, addr, data);
  endtask

  // Unlock sequence followed by a command byte at the first unlock address.
  task automatic issue_command(input logic [7:0] cmd);
    bus_write(ADDR_UNLOCK1, UNLOCK_BYTE1);
    bus_write(ADDR_UNLOCK2, UNLOCK_BYTE2);
    bus_write(ADDR_UNLOCK1, cmd);
  endtask

  task automatic program_byte(input logic [31:0] addr, input logic [7:0] data);
    issue_command(CMD_PROGRAM);
    bus_write(addr, data);
    programmed_addrs.push_back(addr);
    if (programmed_addrs.size() > 16) begin
      void'(programmed_addrs.pop_front());
    end
  endtask

  task automatic switch_bank(input logic [7:0] data);
    issue_command(CMD_BANK_SELECT);
    bus_write(ADDR_BASE, data);
  endtask

  // Unlock sequence followed by the sector erase byte at the sector address.
  task automatic erase_sector_cmd(input logic [3:0] sector);
    bus_write(ADDR_UNLOCK1, UNLOCK_BYTE1);
    bus_write(ADDR_UNLOCK2, UNLOCK_BYTE2);
    bus_write(ADDR_BASE | {16'h0, sector, 12'h000}, CMD_SECTOR_ERASE);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ends a phase with a read, which can only be taken once all earlier
  // writes and fills are done, then waits for all read data.
  task automatic drain();
    bus_read(ADDR_BASE);
    in_valid <= 1'b0;
    do @(posedge clk); while (reads_in_flight != 0);
    repeat (8) @(posedge clk);
    burst_left = 0;
  endtask

  // Mostly addresses that hit programmed bytes, ID offsets or the top sector.
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    logic [15:0] upper;
    upper = ($urandom_range(0, 1) == 1) ? 16'h0E00 : 16'($urandom());
    case ($urandom_range(0, 9))
      0, 1: a = $urandom();
      2:    a = {upper, 16'($urandom_range(0, 3))};
      3:    a = {upper, 16'($urandom_range(16'hF000, 16'hFFFF))};
      4, 5, 6, 7: begin
        if (programmed_addrs.size() > 0) begin
          a = {upper, programmed_addrs[$urandom_range(0, programmed_addrs.size() - 1)][15:0]};
        end else begin
          a = {upper, 16'($urandom())};
        end
      end
      default: a = ADDR_BASE | $urandom_range(0, 16'hFFFF);
    endcase
    return a;
  endfunction

  // Random command traffic: mostly well-formed sequences, some broken ones.
  task automatic run_random(input int unsigned target);
    int unsigned counted;
    int unsigned start;
    int unsigned kind;
    logic [7:0]  cmd;
    counted = 0;
    while (counted < target) begin
      start = items_sent;
      kind  = $urandom_range(0, 99);
      if (kind < 30) begin
        program_byte(pick_addr(), 8'($urandom()));
      end else if (kind < 58) begin
        bus_read(pick_addr());
      end else if (kind < 64) begin
        issue_command(($urandom_range(0, 1) == 1) ? CMD_ID_ENTER : CMD_ID_LEAVE);
      end else if (kind < 71) begin
        switch_bank(8'($urandom()));
      end else if (kind < 77) begin
        issue_command(CMD_ERASE_ARM);
        erase_sector_cmd(4'($urandom()));
      end else if (kind < 80) begin
        // Erase without arming, or arming alone.
        if ($urandom_range(0, 1) == 1) begin
          erase_sector_cmd(4'($urandom()));
        end else begin
          issue_command(CMD_ERASE_ARM);
        end
      end else if (kind == 80 && chip_erases_left > 0) begin
        chip_erases_left--;
        issue_command(CMD_ERASE_ARM);
        issue_command(CMD_CHIP_ERASE);
      end else begin
        case ($urandom_range(0, 3))
          0: bus_write(pick_addr(), 8'($urandom()));
          1: begin
            bus_write(ADDR_UNLOCK1, UNLOCK_BYTE1);
            bus_write(($urandom_range(0, 1) == 1) ? ADDR_UNLOCK2 : pick_addr(), 8'($urandom()));
          end
          2: begin
            // Mostly unknown commands; a chip erase stays within its budget.
            cmd = 8'($urandom());
            if (cmd == CMD_CHIP_ERASE) begin
              cmd = CMD_SECTOR_ERASE;
            end
            issue_command(cmd);
          end
          default: begin
            bus_write(ADDR_UNLOCK1, UNLOCK_BYTE1);
            bus_write(ADDR_UNLOCK2, UNLOCK_BYTE2);
            bus_write($urandom(), 8'($urandom()));
          end
        endcase
      end
      counted += items_sent - start;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = ACC_READ;
    in_bus_address   = '0;
    in_write_byte    = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_LARGE_PART;
    cfg_data         = '0;
    burst_left       = 0;
    items_sent       = 0;
    chip_erases_left = 2;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: two-bank part with extreme ID bytes.
    write_reg(CFG_LARGE_PART, 8'h01);
    write_reg(CFG_MAKER_ID, 8'h00);
    write_reg(CFG_DEVICE_CODE, 8'hFF);
    write_reg(CFG_UNUSED, 8'hA5);
    bus_read(32'h0000_0000);
    bus_read(32'hFFFF_FFFF);
    // A wrong unlock byte leaves the sequencer where it was.
    bus_write(ADDR_UNLOCK1, UNLOCK_BYTE2);
    issue_command(CMD_ID_ENTER);
    bus_read(ADDR_BASE);
    bus_read(ADDR_BASE | 32'h1);
    bus_read(ADDR_BASE | 32'h2);
    issue_command(CMD_ID_LEAVE);
    program_byte(32'hFFFF_FFFF, 8'h00);
    switch_bank(8'hFF);
    bus_read(32'h0E00_FFFF);
    switch_bank(8'h00);
    bus_read(32'h0000_FFFF);
    // Erase commands without arming are ignored.
    issue_command(CMD_CHIP_ERASE);
    erase_sector_cmd(4'hF);
    bus_read(32'h0E00_FFFF);
    issue_command(CMD_ERASE_ARM);
    issue_command(CMD_CHIP_ERASE);
    // Unknown command byte.
    issue_command(8'h00);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(CFG_LARGE_PART, 8'h00);
          write_reg(CFG_MAKER_ID, 8'hFF);
          write_reg(CFG_DEVICE_CODE, 8'h00);
        end
        1: begin
          write_reg(CFG_LARGE_PART, 8'hFF);
          write_reg(CFG_MAKER_ID, 8'($urandom()));
          write_reg(CFG_DEVICE_CODE, 8'($urandom()));
          write_reg(CFG_UNUSED, 8'($urandom()));
        end
        2: begin
          write_reg(CFG_LARGE_PART, 8'hFE);
          write_reg(CFG_MAKER_ID, 8'($urandom()));
          write_reg(CFG_DEVICE_CODE, 8'($urandom()));
        end
        default: begin
          write_reg(CFG_LARGE_PART, 8'h01);
          write_reg(CFG_MAKER_ID, 8'hFF);
          write_reg(CFG_DEVICE_CODE, 8'hFF);
        end
      endcase
      run_random(PHASE_ITEMS);
      drain();
    end

    if (mismatches == 0) begin
      $display("flash_command_interface: match");
    end else begin
      $display("flash_command_interface: mismatch");
    end
    $finish;
  end

endmodule
